### rtl/ellipse_contour_visibility_macros.svh
// assertion macros for the ellipse contour visibility block
`ifndef ELLIPSE_CONTOUR_VISIBILITY_MACROS_SVH
`define ELLIPSE_CONTOUR_VISIBILITY_MACROS_SVH
`ifndef ASSERT_OFF
`define ECV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ECV_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ECV_ASSERT(lbl, prop, msg)
`define ECV_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/ecv_pkg.sv
// shared types, constants, trig table and micro program of the contour block
`default_nettype none
package ecv_pkg;

  localparam int unsigned MAX_POINTS = 36;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned OP_W       = 28;
  localparam int unsigned PROD_W     = 2 * OP_W;
  localparam int unsigned ACC_W      = 90;
  localparam int unsigned UOP_W      = 5;
  localparam int unsigned PROG_LEN   = 28;
  localparam int unsigned PT_START   = 2;

  typedef enum logic [2:0] {
    CFG_MAJOR = 3'd0,
    CFG_MINOR = 3'd1,
    CFG_STEP  = 3'd2,
    CFG_S0X   = 3'd3,
    CFG_S0Y   = 3'd4,
    CFG_S1X   = 3'd5,
    CFG_S1Y   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]         major;
    logic [7:0]         minor;
    logic [8:0]         step;
    logic signed [11:0] s0x;
    logic signed [11:0] s0y;
    logic signed [11:0] s1x;
    logic signed [11:0] s1y;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_ZERO, OP_A, OP_B, OP_COS_T, OP_SIN_T, OP_C, OP_S, OP_X0, OP_Y0,
    OP_AA, OP_BB, OP_NX, OP_NY, OP_VX, OP_VY, OP_DX, OP_DY,
    OP_FH, OP_FL, OP_DD, OP_NH, OP_NL
  } op_e;

  typedef enum logic [1:0] {SH_0, SH_23, SH_27, SH_44} sh_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_AA, WB_BB, WB_X0, WB_Y0, WB_NX, WB_NY, WB_PX, WB_PY,
    WB_VX, WB_VY, WB_DD, WB_INNER, WB_NN, WB_VIS
  } wb_e;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
    sh_e  sh;
    wb_e  wb;
  } acc_ctl_t;

  typedef struct packed {
    op_e      opa;
    op_e      opb;
    acc_ctl_t ctl;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  localparam logic [15:0] SIN_Q15 [0:90] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
    16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384,
    16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
    16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926,
    16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166,
    16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
    16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792,
    16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
    16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32644, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
  };

  // angle in 0..359
  function automatic logic signed [16:0] sin_deg(input logic [8:0] d);
    logic [8:0] k;
    logic       neg;
    if (d <= 9'd90) begin
      k = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      k = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      k = d - 9'd180;
      neg = 1'b1;
    end else begin
      k = 9'd360 - d;
      neg = 1'b1;
    end
    sin_deg = neg ? -$signed({1'b0, SIN_Q15[k[6:0]]}) : $signed({1'b0, SIN_Q15[k[6:0]]});
  endfunction

  function automatic logic signed [16:0] cos_deg(input logic [8:0] d);
    logic [9:0] e;
    e = {1'b0, d} + 10'd90;
    if (e >= 10'd360) begin
      e = e - 10'd360;
    end
    cos_deg = sin_deg(e[8:0]);
  endfunction

  function automatic uop_t mk(input op_e a, input op_e b, input logic clr,
                              input logic sub, input sh_e sh, input wb_e wb);
    uop_t u;
    u.opa = a;
    u.opb = b;
    u.ctl.en = 1'b1;
    u.ctl.clr = clr;
    u.ctl.sub = sub;
    u.ctl.sh = sh;
    u.ctl.wb = wb;
    mk = u;
  endfunction

  // an issued slot passes the product register, then the accumulator, and is then written back
  function automatic uop_t prog(input logic [UOP_W-1:0] idx);
    uop_t u;
    u = '{opa: OP_ZERO, opb: OP_ZERO, ctl: '{en: 1'b0, clr: 1'b0, sub: 1'b0,
                                            sh: SH_0, wb: WB_NONE}};
    case (idx)
      5'd0:  u = mk(OP_A,     OP_A,     1'b1, 1'b0, SH_0,  WB_AA);
      5'd1:  u = mk(OP_B,     OP_B,     1'b1, 1'b0, SH_0,  WB_BB);
      5'd2:  u = mk(OP_A,     OP_COS_T, 1'b1, 1'b0, SH_0,  WB_X0);
      5'd3:  u = mk(OP_B,     OP_SIN_T, 1'b1, 1'b0, SH_0,  WB_Y0);
      5'd5:  u = mk(OP_BB,    OP_X0,    1'b1, 1'b0, SH_0,  WB_NX);
      5'd6:  u = mk(OP_AA,    OP_Y0,    1'b1, 1'b0, SH_0,  WB_NY);
      5'd7:  u = mk(OP_C,     OP_X0,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd8:  u = mk(OP_S,     OP_Y0,    1'b0, 1'b1, SH_0,  WB_PX);
      5'd9:  u = mk(OP_C,     OP_NX,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd10: u = mk(OP_S,     OP_NY,    1'b0, 1'b1, SH_0,  WB_VX);
      5'd11: u = mk(OP_S,     OP_X0,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd12: u = mk(OP_C,     OP_Y0,    1'b0, 1'b0, SH_0,  WB_PY);
      5'd13: u = mk(OP_S,     OP_NX,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd14: u = mk(OP_C,     OP_NY,    1'b0, 1'b0, SH_0,  WB_VY);
      5'd15: u = mk(OP_DX,    OP_DX,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd16: u = mk(OP_DY,    OP_DY,    1'b0, 1'b0, SH_0,  WB_DD);
      5'd17: u = mk(OP_VX,    OP_DX,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd18: u = mk(OP_VY,    OP_DY,    1'b0, 1'b0, SH_0,  WB_INNER);
      5'd19: u = mk(OP_VX,    OP_VX,    1'b1, 1'b0, SH_0,  WB_NONE);
      5'd20: u = mk(OP_VY,    OP_VY,    1'b0, 1'b0, SH_0,  WB_NN);
      5'd21: u = mk(OP_FH,    OP_FH,    1'b1, 1'b0, SH_44, WB_NONE);
      5'd22: u = mk(OP_FH,    OP_FL,    1'b0, 1'b0, SH_23, WB_NONE);
      5'd23: u = mk(OP_FL,    OP_FL,    1'b0, 1'b0, SH_0,  WB_NONE);
      5'd24: u = mk(OP_DD,    OP_NH,    1'b0, 1'b1, SH_27, WB_NONE);
      5'd25: u = mk(OP_DD,    OP_NL,    1'b0, 1'b1, SH_0,  WB_VIS);
      default: ;
    endcase
    prog = u;
  endfunction

endpackage
`default_nettype wire

### rtl/ecv_cfg.sv
// configuration register bank
`default_nettype none
module ecv_cfg
  import ecv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire logic [2:0]  index_i,
  input  wire logic [11:0] data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      unique case (index_i)
        CFG_MAJOR: cfg_d.major = data_i[7:0];
        CFG_MINOR: cfg_d.minor = data_i[7:0];
        CFG_STEP:  cfg_d.step  = data_i[8:0];
        CFG_S0X:   cfg_d.s0x   = $signed(data_i);
        CFG_S0Y:   cfg_d.s0y   = $signed(data_i);
        CFG_S1X:   cfg_d.s1x   = $signed(data_i);
        CFG_S1Y:   cfg_d.s1y   = $signed(data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{major: 8'd40, minor: 8'd20, step: 9'd10,
                 s0x: 12'sd0, s0y: 12'sd0, s1x: 12'sd0, s1y: 12'sd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### rtl/ecv_mac.sv
// shared multiplier with shift-accumulate stage
`default_nettype none
module ecv_mac
  import ecv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire acc_ctl_t                ctl_i,
  input  wire logic signed [OP_W-1:0]  opa_i,
  input  wire logic signed [OP_W-1:0]  opb_i,
  output logic signed [ACC_W-1:0]      acc_o,
  output wb_e                          wb_o
);

  logic signed [PROD_W-1:0] p_q;
  acc_ctl_t                 c1_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, ext, term, base;
  wb_e                      wb_q;

  always_comb begin
    ext = ACC_W'(p_q);
    case (c1_q.sh)
      SH_23:   term = ext <<< 23;
      SH_27:   term = ext <<< 27;
      SH_44:   term = ext <<< 44;
      default: term = ext;
    endcase
    base = c1_q.clr ? '0 : acc_q;
    acc_d = c1_q.sub ? base - term : base + term;
  end

  always_ff @(posedge clk_i) begin
    p_q <= opa_i * opb_i;
    if (c1_q.en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '{en: 1'b0, clr: 1'b0, sub: 1'b0, sh: SH_0, wb: WB_NONE};
      wb_q <= WB_NONE;
    end else begin
      c1_q <= ctl_i;
      wb_q <= c1_q.en ? c1_q.wb : WB_NONE;
    end
  end

  assign acc_o = acc_q;
  assign wb_o  = wb_q;

endmodule
`default_nettype wire

### rtl/ellipse_contour_visibility.sv
// top level: contour point sequencer, operand registers and result register
//
// usage
//   input channel: one request per pose (center, rotation, two in-range flags),
//   taken when in_valid_i is high and in_stall_o low. in_stall_o stays high
//   from acceptance until the last contour point of the pose has been loaded
//   into the result register.
//   output channel: one result per contour point, n = min(floor(360/step), 36)
//   points per pose; a step above 360 gives no points. last_o marks the final one.
//   timing: every arithmetic step goes through one shared 28x28 multiplier and
//   accumulator; a pose first forms the axis squares, then for each point runs
//   the multiply slots of the micro program, lets the pipeline drain and loads
//   the result register.
//   stall: while out_stall_i holds the result register full the sequencer
//   waits before starting the next point; nothing is dropped.
//   reset: registers back to major 40, minor 20, step 10, sensors at 0;
//   the sequencer goes idle and the result register empties.
//   configuration: write channel always ready; write only while idle.
`default_nettype none
`include "ellipse_contour_visibility_macros.svh"
module ellipse_contour_visibility
  import ecv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  center_x_i,
  input  wire logic [9:0]  center_y_i,
  input  wire logic [8:0]  rotation_deg_i,
  input  wire logic        in_range_first_i,
  input  wire logic        in_range_second_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       point_index_o,
  output logic signed [11:0] point_x_o,
  output logic signed [11:0] point_y_o,
  output logic             visible_o,
  output logic [5:0]       visible_count_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  cfg_t cfg;

  // configuration bank, always ready
  assign cfg_ready_o = 1'b1;

  ecv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // sequencer state
  state_e                  state_q, state_d;
  logic [UOP_W-1:0]        uop_q, uop_d;
  logic [5:0]              i_q, i_d;
  logic [5:0]              tally_q, tally_d;
  logic [8:0]              t_q, t_d;
  logic [9:0]              u_q, u_d;

  // per-pose operands
  logic [8:0]              step_q;
  logic signed [16:0]      c_q, s_q;
  logic signed [11:0]      sx_q, sy_q;
  logic [9:0]              cx_q, cy_q;

  // per-point operands
  logic [15:0]             aa_q, bb_q;
  logic signed [9:0]       x0_q, y0_q;
  logic signed [26:0]      nx_q, ny_q;
  logic signed [11:0]      px_q, py_q;
  logic signed [27:0]      vx_q, vy_q;
  logic [25:0]             dd_q;
  logic signed [44:0]      f_q;
  logic                    inner_pos_q;
  logic [54:0]             nn_q;
  logic                    vis_q;

  // result register
  logic                    out_valid_q;
  logic [5:0]              out_index_q, out_count_q;
  logic signed [11:0]      out_x_q, out_y_q;
  logic                    out_vis_q, out_last_q;

  logic                    accept, out_load, last_pt;
  logic [8:0]              rot_mod, step_eff;
  logic [9:0]              t_sum;
  logic [10:0]             u_next;
  logic signed [16:0]      cos_t, sin_t;
  logic signed [12:0]      dx, dy;
  uop_t                    uop;
  acc_ctl_t                issue;
  logic signed [OP_W-1:0]  opa, opb;
  logic signed [ACC_W-1:0] acc;
  wb_e                     wb;
  logic signed [47:0]      r_in, r_sum, rnd;
  logic signed [44:0]      inner_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign rot_mod  = (rotation_deg_i >= 9'd360) ? rotation_deg_i - 9'd360 : rotation_deg_i;
  assign step_eff = (cfg.step == 9'd0) ? 9'd1 : cfg.step;

  assign cos_t = cos_deg(t_q);
  assign sin_t = sin_deg(t_q);
  assign dx    = 13'(sx_q) - 13'(px_q);
  assign dy    = 13'(sy_q) - 13'(py_q);

  // u_q holds (i+1)*step: point i exists while it stays within a full turn
  assign u_next  = {1'b0, u_q} + {2'b00, step_q};
  assign last_pt = (i_q == 6'(MAX_POINTS - 1)) || (u_next > 11'd360);
  assign t_sum   = {1'b0, t_q} + {1'b0, step_q};
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // micro program slot issued this cycle
  assign uop   = prog(uop_q);
  always_comb begin
    issue = uop.ctl;
    if (state_q != ST_RUN) begin
      issue.en = 1'b0;
    end
  end

  function automatic logic signed [OP_W-1:0] pick(input op_e op);
    logic signed [OP_W-1:0] v;
    case (op)
      OP_A:     v = $signed({20'd0, cfg.major});
      OP_B:     v = $signed({20'd0, cfg.minor});
      OP_COS_T: v = OP_W'(cos_t);
      OP_SIN_T: v = OP_W'(sin_t);
      OP_C:     v = OP_W'(c_q);
      OP_S:     v = OP_W'(s_q);
      OP_X0:    v = OP_W'(x0_q);
      OP_Y0:    v = OP_W'(y0_q);
      OP_AA:    v = $signed({12'd0, aa_q});
      OP_BB:    v = $signed({12'd0, bb_q});
      OP_NX:    v = OP_W'(nx_q);
      OP_NY:    v = OP_W'(ny_q);
      OP_VX:    v = vx_q;
      OP_VY:    v = vy_q;
      OP_DX:    v = OP_W'(dx);
      OP_DY:    v = OP_W'(dy);
      OP_FH:    v = OP_W'($signed(f_q[44:22]));
      OP_FL:    v = $signed({6'd0, f_q[21:0]});
      OP_DD:    v = $signed({2'd0, dd_q});
      // |n|^2 stays below 2^51, so the upper slice is never negative
      OP_NH:    v = $signed(nn_q[54:27]);
      OP_NL:    v = $signed({1'b0, nn_q[26:0]});
      default:  v = '0;
    endcase
    pick = v;
  endfunction

  always_comb begin
    opa = pick(uop.opa);
    opb = pick(uop.opb);
  end

  ecv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (issue),
    .opa_i  (opa),
    .opb_i  (opb),
    .acc_o  (acc),
    .wb_o   (wb)
  );

  // divide by 2^15, rounding half away from zero
  always_comb begin
    r_in  = $signed(acc[47:0]);
    r_sum = r_in + (r_in[47] ? 48'sd16383 : 48'sd16384);
    rnd   = r_sum >>> 15;
    inner_ext = 45'($signed(acc[41:0]));
  end

  // writeback from the accumulator
  always_ff @(posedge clk_i) begin
    case (wb)
      WB_AA:    aa_q <= acc[15:0];
      WB_BB:    bb_q <= acc[15:0];
      WB_X0:    x0_q <= rnd[9:0];
      WB_Y0:    y0_q <= rnd[9:0];
      WB_NX:    nx_q <= acc[26:0];
      WB_NY:    ny_q <= acc[26:0];
      WB_PX:    px_q <= rnd[11:0] + {2'b00, cx_q};
      WB_PY:    py_q <= rnd[11:0] + {2'b00, cy_q};
      WB_VX:    vx_q <= rnd[27:0];
      WB_VY:    vy_q <= rnd[27:0];
      WB_DD:    dd_q <= acc[25:0];
      WB_INNER: begin
        // 5*inner, split later into two halves for the exact square
        f_q <= (inner_ext <<< 2) + inner_ext;
        inner_pos_q <= !acc[41] && (acc[41:0] != '0);
      end
      WB_NN:    nn_q <= acc[54:0];
      // 25*inner^2 - |d|^2*|n|^2 must be strictly positive
      WB_VIS:   vis_q <= !acc[ACC_W-1] && (acc != '0) && inner_pos_q &&
                         (dd_q != '0) && (nn_q != '0);
      default: ;
    endcase
  end

  // pose registers captured on acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_q <= step_eff;
      c_q    <= cos_deg(rot_mod);
      s_q    <= sin_deg(rot_mod);
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      // sensor 1 only when the first flag is clear and the second set
      if (!in_range_first_i && in_range_second_i) begin
        sx_q <= cfg.s1x;
        sy_q <= cfg.s1y;
      end else begin
        sx_q <= cfg.s0x;
        sy_q <= cfg.s0y;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    uop_d   = uop_q;
    i_d     = i_q;
    tally_d = tally_q;
    t_d     = t_q;
    u_d     = u_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          uop_d   = '0;
          i_d     = '0;
          tally_d = '0;
          t_d     = 9'd180;
          u_d     = {1'b0, step_eff};
          state_d = (step_eff > 9'd360) ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        uop_d = uop_q + 1'b1;
        if (uop_q == UOP_W'(PROG_LEN - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          tally_d = tally_q + {5'd0, vis_q};
          if (last_pt) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
            uop_d   = UOP_W'(PT_START);
            i_d     = i_q + 1'b1;
            u_d     = u_next[9:0];
            t_d     = (t_sum >= 10'd360) ? 9'(t_sum - 10'd360) : t_sum[8:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      uop_q   <= '0;
      i_q     <= '0;
      tally_q <= '0;
      t_q     <= '0;
      u_q     <= '0;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
      i_q     <= i_d;
      tally_q <= tally_d;
      t_q     <= t_d;
      u_q     <= u_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= i_q;
      out_x_q     <= px_q;
      out_y_q     <= py_q;
      out_vis_q   <= vis_q;
      out_count_q <= tally_q + {5'd0, vis_q};
      out_last_q  <= last_pt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign point_index_o   = out_index_q;
  assign point_x_o       = out_x_q;
  assign point_y_o       = out_y_q;
  assign visible_o       = out_vis_q;
  assign visible_count_o = out_count_q;
  assign last_o          = out_last_q;

  `ECV_ASSERT(a_count_le_index, out_valid_q |-> (out_count_q <= out_index_q + 6'd1), "tally ahead of index")
  `ECV_ASSERT_NEVER(a_index_range, out_valid_q && (out_index_q >= 6'(MAX_POINTS)), "index out of range")
  `ECV_ASSERT(a_last_to_idle, (out_load && last_pt) |=> (state_q == ST_IDLE), "no return to idle")
  `ECV_ASSERT(a_uop_range, (state_q == ST_RUN) |-> (uop_q < UOP_W'(PROG_LEN)), "program overrun")

endmodule
`default_nettype wire

### verif/tb.sv
// testbench of the ellipse contour visibility block: queue driver, monitor, contour predictor
`default_nettype none
module tb
  import ecv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 1100;   // room for one full 36-point pose to finish
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [8:0] rot;
    logic       first;
    logic       second;
  } pose_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic               vis;
    logic [5:0]         cnt;
    logic               last;
  } point_t;

  logic clk_i, rst_ni;
  logic in_valid, in_stall_o;
  logic [9:0] cx_d, cy_d;
  logic [8:0] rot_d;
  logic first_d, second_d;
  logic out_valid_o, out_stall;
  logic [5:0] point_index_o, visible_count_o;
  logic signed [11:0] point_x_o, point_y_o;
  logic visible_o, last_o;
  logic cfg_valid, cfg_ready_o;
  cfg_idx_e cfg_index;
  logic [11:0] cfg_data;

  ellipse_contour_visibility u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .center_x_i(cx_d), .center_y_i(cy_d), .rotation_deg_i(rot_d),
    .in_range_first_i(first_d), .in_range_second_i(second_d),
    .out_valid_o, .out_stall_i(out_stall),
    .point_index_o, .point_x_o, .point_y_o, .visible_o, .visible_count_o, .last_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // shadow copy of the register file
  logic [7:0] sh_major, sh_minor;
  logic [8:0] sh_step;
  logic signed [11:0] sh_s0x, sh_s0y, sh_s1x, sh_s1y;

  pose_t  pose_q[$];
  point_t contour_q[$];
  int errors, cycles, n_poses, n_points, n_visible;
  logic in_taken, calm, hold_go, held;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // signed q15 sine of a whole degree, mirrored from the first quadrant
  function automatic longint sin_q(int d);
    d = d % 360;
    if (d <= 90) return longint'(SIN_Q15[d]);
    if (d <= 180) return longint'(SIN_Q15[180 - d]);
    if (d <= 270) return -longint'(SIN_Q15[d - 180]);
    return -longint'(SIN_Q15[360 - d]);
  endfunction

  function automatic longint cos_q(int d);
    return sin_q((d % 360) + 90);
  endfunction

  // divide by 2^15, half away from zero
  function automatic longint round_q15(longint v);
    if (v < 0) return -((-v + 16384) >>> 15);
    return (v + 16384) >>> 15;
  endfunction

  task automatic predict_contour(input pose_t p);
    longint a, b, c, s, sx, sy, x0, y0, nx, ny, vx, vy, dx, dy, inner, five;
    logic signed [11:0] px, py;
    logic [127:0] lhs, rhs, dd, nn;
    int rt, stp, n, t, tally;
    logic sel;
    point_t r;
    a = sh_major;
    b = sh_minor;
    rt = p.rot % 360;
    c = cos_q(rt);
    s = sin_q(rt);
    stp = (sh_step == 0) ? 1 : sh_step;
    n = 360 / stp;
    if (n > MAX_POINTS) n = MAX_POINTS;
    sel = !p.first && p.second;
    sx = sel ? sh_s1x : sh_s0x;
    sy = sel ? sh_s1y : sh_s0y;
    tally = 0;
    for (int i = 0; i < n; i++) begin
      t = (i * stp + 180) % 360;
      x0 = round_q15(a * cos_q(t));
      y0 = round_q15(b * sin_q(t));
      nx = b * b * x0;
      ny = a * a * y0;
      px = 12'(round_q15(c * x0 - s * y0) + longint'(p.cx));
      py = 12'(round_q15(s * x0 + c * y0) + longint'(p.cy));
      vx = round_q15(c * nx - s * ny);
      vy = round_q15(s * nx + c * ny);
      dx = sx - longint'(px);
      dy = sy - longint'(py);
      inner = vx * dx + vy * dy;
      dd = 128'(dx * dx + dy * dy);
      nn = 128'(vx * vx + vy * vy);
      r.vis = 1'b0;
      if (inner > 0 && dd != 0 && nn != 0) begin
        five = 5 * inner;
        lhs = 128'(five);
        lhs = lhs * lhs;
        rhs = dd * nn;
        r.vis = lhs > rhs;
      end
      tally += r.vis;
      r.idx = 6'(i);
      r.px = px;
      r.py = py;
      r.cnt = 6'(tally);
      r.last = (i + 1 == n);
      contour_q.push_back(r);
    end
  endtask

  // request acceptance, prediction and result checking
  always @(posedge clk_i) begin
    point_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ellipse_contour_visibility test failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (contour_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point idx %0d", point_index_o);
      end else begin
        e = contour_q.pop_front();
        n_points++;
        n_visible += e.vis;
        if (e.idx !== point_index_o || e.px !== point_x_o || e.py !== point_y_o ||
            e.vis !== visible_o || e.cnt !== visible_count_o || e.last !== last_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                     e.idx, e.px, e.py, e.vis, e.cnt, e.last, point_index_o, point_x_o,
                     point_y_o, visible_o, visible_count_o, last_o);
        end
      end
    end
    in_taken <= rst_ni && in_valid && !in_stall_o;
    if (rst_ni && in_valid && !in_stall_o) begin
      predict_contour('{cx_d, cy_d, rot_d, first_d, second_d});
      n_poses++;
    end
  end

  // pose driver: payload holds while stalled
  always @(negedge clk_i) begin
    pose_t p;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pose_q.size() == 0 || (!calm && $urandom_range(0, 99) < 32)) begin
        in_valid <= 1'b0;
      end else begin
        p = pose_q.pop_front();
        in_valid <= 1'b1;
        cx_d <= p.cx;
        cy_d <= p.cy;
        rot_d <= p.rot;
        first_d <= p.first;
        second_d <= p.second;
      end
    end
  end

  // result receiver: random stalls, one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (hold_go && !held) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [11:0] d);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAJOR: sh_major = d[7:0];
      CFG_MINOR: sh_minor = d[7:0];
      CFG_STEP:  sh_step = d[8:0];
      CFG_S0X:   sh_s0x = d;
      CFG_S0Y:   sh_s0y = d;
      CFG_S1X:   sh_s1x = d;
      CFG_S1Y:   sh_s1y = d;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_all(input logic [7:0] a, input logic [7:0] b, input logic [8:0] st,
                         input logic [11:0] s0x, input logic [11:0] s0y,
                         input logic [11:0] s1x, input logic [11:0] s1y);
    cfg_write(CFG_MAJOR, {4'd0, a});
    cfg_write(CFG_MINOR, {4'd0, b});
    cfg_write(CFG_STEP, {3'd0, st});
    cfg_write(CFG_S0X, s0x);
    cfg_write(CFG_S0Y, s0y);
    cfg_write(CFG_S1X, s1x);
    cfg_write(CFG_S1Y, s1y);
  endtask

  // wait for the block to finish everything queued, poses with no points included
  task automatic drain();
    do @(posedge clk_i); while (pose_q.size() != 0 || in_valid || contour_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_pose(input int x, input int y, input int r, input int f, input int s);
    pose_q.push_back('{10'(x), 10'(y), 9'(r), 1'(f), 1'(s)});
  endtask

  initial begin
    errors = 0; cycles = 0; n_poses = 0; n_points = 0; n_visible = 0;
    rst_ni = 1'b0; in_valid = 1'b0; in_taken = 1'b0; out_stall = 1'b0;
    cx_d = '0; cy_d = '0; rot_d = '0; first_d = 1'b0; second_d = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_MAJOR; cfg_data = '0;
    calm = 1'b0; hold_go = 1'b0; held = 1'b0; hold_left = 0;
    sh_major = 8'd40; sh_minor = 8'd20; sh_step = 9'd10;
    sh_s0x = '0; sh_s0y = '0; sh_s1x = '0; sh_s1y = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: center and rotation extremes, rotation past 359, all flag pairs
    push_pose(0, 0, 0, 0, 0);
    push_pose(1023, 1023, 359, 1, 0);
    push_pose(512, 300, 90, 0, 1);
    push_pose(1023, 0, 180, 1, 1);
    push_pose(0, 1023, 360, 0, 1);
    push_pose(700, 200, 511, 1, 0);
    push_pose(341, 682, 45, 0, 0);
    drain();
    // widest ellipse, sensors at the coordinate extremes
    cfg_all(8'd255, 8'd255, 9'd10, 12'h800, 12'h7ff, 12'h7ff, 12'h800);
    push_pose(1023, 1023, 270, 1, 0);
    push_pose(0, 0, 135, 0, 1);
    push_pose(512, 512, 1, 0, 0);
    drain();
    // zero axes collapse the contour; single point per pose
    cfg_all(8'd0, 8'd0, 9'd360, 12'd100, 12'd100, 12'd900, 12'd900);
    push_pose(100, 100, 30, 1, 0);
    push_pose(500, 500, 300, 0, 1);
    drain();
    cfg_all(8'd1, 8'd1, 9'd360, 12'd0, 12'd0, 12'd1000, 12'd20);
    push_pose(3, 7, 0, 1, 1);
    drain();
    // step above 360: no points at all
    cfg_write(CFG_STEP, 12'd361);
    push_pose(10, 20, 10, 0, 1);
    drain();
    cfg_write(CFG_STEP, 12'd511);
    push_pose(900, 20, 200, 1, 0);
    drain();
    // step of zero and step below ten saturate at the point limit
    cfg_all(8'd30, 8'd60, 9'd0, 12'd0, 12'd0, 12'd500, 12'd500);
    push_pose(400, 400, 77, 0, 1);
    drain();
    cfg_write(CFG_STEP, 12'd5);
    push_pose(600, 450, 12, 1, 0);
    drain();

    // random phases: fresh settings, then a batch of poses
    for (int ph = 0; ph < 10; ph++) begin
      int st;
      st = ($urandom_range(0, 9) < 7) ? $urandom_range(10, 45) : $urandom_range(0, 511);
      cfg_all(8'($urandom_range(0, 9) < 8 ? $urandom_range(1, 120) : $urandom_range(0, 255)),
              8'($urandom_range(0, 9) < 8 ? $urandom_range(1, 120) : $urandom_range(0, 255)),
              9'(st),
              $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 1023)),
              $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 1023)),
              $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 1023)),
              $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 1023)));
      calm = (ph == 2);
      if (ph == 4) hold_go = 1'b1;
      for (int k = 0; k < 10; k++)
        push_pose($urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 9) < 8 ? $urandom_range(0, 359) : $urandom_range(0, 511),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      drain();
    end

    if (contour_q.size() != 0) begin
      errors++;
      $display("%0d points never arrived", contour_q.size());
    end
    $display("%0d poses over 18 register settings, %0d contour points checked, %0d visible",
             n_poses, n_points, n_visible);
    if (errors == 0) begin
      $display("ellipse_contour_visibility test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("ellipse_contour_visibility test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/ecv_pkg.sv
rtl/ecv_cfg.sv
rtl/ecv_mac.sv
rtl/ellipse_contour_visibility.sv
verif/tb.sv
